// File: hw/rtl/mh64a_pkg.sv
// shared constants and helpers for the murmur hash 64a block
// no dependencies
package mh64a_pkg;

    localparam logic [63:0] MUL_M   = 64'hc6a4a7935bd1e995;
    localparam int          SHIFT_R = 47;

    // keep the low nbytes bytes of a word, nbytes in 1..7
    function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
        logic [63:0] mask;
        begin
            case (nbytes)
                4'd1:    mask = 64'h0000_0000_0000_00ff;
                4'd2:    mask = 64'h0000_0000_0000_ffff;
                4'd3:    mask = 64'h0000_0000_00ff_ffff;
                4'd4:    mask = 64'h0000_0000_ffff_ffff;
                4'd5:    mask = 64'h0000_00ff_ffff_ffff;
                4'd6:    mask = 64'h0000_ffff_ffff_ffff;
                4'd7:    mask = 64'h00ff_ffff_ffff_ffff;
                default: mask = 64'hffff_ffff_ffff_ffff;
            endcase
            return mask;
        end
    endfunction

    function automatic logic [63:0] xor_shift(input logic [63:0] value);
        return value ^ (value >> SHIFT_R);
    endfunction

endpackage

// File: hw/rtl/murmur_hash_64a.sv
// streaming murmur hash 64a, top level; depends on mh64a_pkg and mh64a_mul
// each 64-bit multiply by the constant runs as LL, LH and HL partial products on the one shared 32x32 multiplier
// multiplies per beat: 3 for a full word, 1 for a tail, 0 when empty, one more on the first beat and one on the last
// async active-low reset clears the seed, running hash, message flag, sequencer state and output valid flag
module murmur_hash_64a
    import mh64a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] hash_seed,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_word,
    input  logic [3:0]  valid_bytes,
    input  logic        first_item,
    input  logic        last_item,
    input  logic [31:0] message_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_MIX,
        S_K1,
        S_K2,
        S_H,
        S_LAST,
        S_FIN,
        S_EMIT
    } state_t;

    state_t      state_reg;
    logic [31:0] seed_reg;
    logic [63:0] hash_reg;
    logic        in_message_reg;
    logic [63:0] word_reg;
    logic [3:0]  nbytes_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [63:0] result_reg;

    logic        accept;
    logic [3:0]  nbytes_clamped;
    logic        mul_start;
    logic [63:0] mul_operand;
    logic        mul_done;
    logic [63:0] mul_product;

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == S_IDLE);
    assign accept         = in_valid && in_ready;
    assign nbytes_clamped = valid_bytes[3] ? 4'd8 : valid_bytes;

    always_comb
    begin
        mul_start   = 1'b0;
        mul_operand = hash_reg;
        case (state_reg)
            S_IDLE:
            begin
                mul_start   = accept && first_item;
                mul_operand = {32'b0, message_length};
            end
            S_MIX:
            begin
                mul_start = (nbytes_reg != 4'd0);
                if (nbytes_reg == 4'd8)
                begin
                    mul_operand = word_reg;
                end
                else
                begin
                    mul_operand = hash_reg ^ (word_reg & byte_mask(nbytes_reg));
                end
            end
            S_K1:
            begin
                mul_start   = mul_done;
                mul_operand = xor_shift(mul_product);
            end
            S_K2:
            begin
                mul_start   = mul_done;
                mul_operand = hash_reg ^ mul_product;
            end
            S_LAST:
            begin
                mul_start   = last_reg;
                mul_operand = xor_shift(hash_reg);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    mh64a_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .done    (mul_done),
        .product (mul_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seed_reg       <= 32'b0;
            hash_reg       <= 64'b0;
            in_message_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= hash_seed;
            end
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        word_reg   <= data_word;
                        nbytes_reg <= nbytes_clamped;
                        last_reg   <= last_item;
                        if (first_item)
                        begin
                            state_reg <= S_INIT;
                        end
                        else if (in_message_reg)
                        begin
                            state_reg <= S_MIX;
                        end
                    end
                end
                S_INIT:
                begin
                    if (mul_done)
                    begin
                        hash_reg       <= {32'b0, seed_reg} ^ mul_product;
                        in_message_reg <= 1'b1;
                        state_reg      <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    if (nbytes_reg == 4'd8)
                    begin
                        state_reg <= S_K1;
                    end
                    else if (nbytes_reg != 4'd0)
                    begin
                        state_reg <= S_H;
                    end
                    else
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_K1:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_K2;
                    end
                end
                S_K2:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_H;
                    end
                end
                S_H:
                begin
                    if (mul_done)
                    begin
                        hash_reg  <= mul_product;
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    if (last_reg)
                    begin
                        in_message_reg <= 1'b0;
                        state_reg      <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_FIN:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // product holds in the idle multiplier until the result slot frees
                    if (!out_valid_reg || out_ready)
                    begin
                        result_reg    <= xor_shift(mul_product);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = result_reg;

`ifndef SYNTHESIS
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_INIT || state_reg == S_K1 || state_reg == S_K2
                      || state_reg == S_H || state_reg == S_FIN))
        else $error("multiply finished while sequencer not waiting");
    a_stray_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !first_item && !in_message_reg |=> state_reg == S_IDLE)
        else $error("beat outside a message was not dropped");
    a_fin_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN || state_reg == S_EMIT) |-> !in_message_reg)
        else $error("message still open during finalize");
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && out_valid_reg && !out_ready |=> state_reg == S_EMIT)
        else $error("result overwritten before it was taken");
`endif

endmodule

// File: hw/rtl/mh64a_mul.sv
// shared 64-bit multiply by the hash constant, low 64 bits of the product
// one 32x32 partial product per cycle; depends on mh64a_pkg
module mh64a_mul
    import mh64a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [63:0] product
);

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_LL,
        MS_LH,
        MS_HL
    } mstate_t;

    mstate_t     state_reg;
    logic        done_reg;
    logic [63:0] a_reg;
    logic [63:0] acc_reg;
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] part;
    logic [31:0] hi_next;

    assign x       = (state_reg == MS_HL) ? a_reg[63:32] : a_reg[31:0];
    assign y       = (state_reg == MS_LH) ? MUL_M[63:32] : MUL_M[31:0];
    assign part    = 64'(x) * 64'(y);
    assign hi_next = acc_reg[63:32] + part[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                MS_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= operand;
                        state_reg <= MS_LL;
                    end
                end
                MS_LL:
                begin
                    acc_reg   <= part;
                    state_reg <= MS_LH;
                end
                MS_LH:
                begin
                    acc_reg[63:32] <= hi_next;
                    state_reg      <= MS_HL;
                end
                MS_HL:
                begin
                    acc_reg[63:32] <= hi_next;
                    done_reg       <= 1'b1;
                    state_reg      <= MS_IDLE;
                end
                default:
                begin
                    state_reg <= MS_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == MS_IDLE))
        else $error("multiply started while busy");
    a_done_after_hl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == MS_HL)
        else $error("multiply done without final partial product");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("multiply done held more than one cycle");
`endif

endmodule

// File: tb/sv/tb.sv
// testbench for murmur_hash_64a: directed table then random messages over several seed phases
// predicts each hash in-bench and checks every output beat; depends on the murmur_hash_64a rtl
module tb;

    localparam logic [63:0] HASH_MUL   = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT  = 47;
    localparam int          DRAIN_WAIT = 40;
    localparam int          HOLD_LEN   = 500;
    localparam int unsigned CYCLE_CAP  = 1000000;
    localparam int          DIR_ROWS   = 22;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        first;
        logic        last;
        logic [31:0] length;
        logic        typed;
        logic [63:0] typed_hash;
    } beat_row_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [31:0] seed_in        = '0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [63:0] data_word      = '0;
    logic [3:0]  valid_bytes    = '0;
    logic        first_item     = 1'b0;
    logic        last_item      = 1'b0;
    logic [31:0] message_length = '0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [63:0] hash_value;

    logic [31:0] seed_reg = '0;
    logic [63:0] run_hash = '0;
    bit          msg_open = 1'b0;
    logic [63:0] pending_hashes[$];

    int          send_idle  = 0;
    int          recv_stall = 0;
    logic        hold_start = 1'b0;
    int          hold_left  = 0;
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    murmur_hash_64a dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .hash_seed      (seed_in),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .first_item     (first_item),
        .last_item      (last_item),
        .message_length (message_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hashes.size() == 0)
                report_mismatch("hash_value with nothing pending", hash_value, '0);
            else
            begin
                want = pending_hashes.pop_front();
                if (hash_value !== want)
                    report_mismatch("hash_value", hash_value, want);
            end
        end
        out_ready <= (hold_left == 0) && !hold_start && ($urandom_range(99) >= recv_stall);
    end

    // hash update for one accepted beat; counted is 0 for beats the block ignores
    task automatic absorb_beat(input beat_row_t b, output bit counted);
        logic [63:0] k;
        int          n;
        counted = b.first || msg_open;
        if (!counted)
            return;
        n = (b.nbytes > 8) ? 8 : int'(b.nbytes);
        if (b.first)
        begin
            run_hash = {32'd0, seed_reg} ^ ({32'd0, b.length} * HASH_MUL);
            msg_open = 1'b1;
        end
        if (n == 8)
        begin
            k = b.word * HASH_MUL;
            k = k ^ (k >> MIX_SHIFT);
            k = k * HASH_MUL;
            run_hash = (run_hash ^ k) * HASH_MUL;
        end
        else if (n != 0)
            run_hash = (run_hash ^ (b.word & ~({64{1'b1}} << (8 * n)))) * HASH_MUL;
        if (b.last)
        begin
            k = run_hash ^ (run_hash >> MIX_SHIFT);
            k = k * HASH_MUL;
            k = k ^ (k >> MIX_SHIFT);
            pending_hashes.push_back(b.typed ? b.typed_hash : k);
            msg_open = 1'b0;
        end
    endtask

    task automatic send_beat(input beat_row_t b, output bit counted);
        while (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_word      <= b.word;
        valid_bytes    <= b.nbytes;
        first_item     <= b.first;
        last_item      <= b.last;
        message_length <= b.length;
        do @(posedge clk); while (!in_ready);
        absorb_beat(b, counted);
    endtask

    function automatic beat_row_t mk_row(input logic [63:0] w, input logic [3:0] nb,
                                         input logic f, input logic l, input logic [31:0] len,
                                         input logic typed, input logic [63:0] th);
        beat_row_t r;
        r.word       = w;
        r.nbytes     = nb;
        r.first      = f;
        r.last       = l;
        r.length     = len;
        r.typed      = typed;
        r.typed_hash = th;
        return r;
    endfunction

    function automatic beat_row_t directed_row(input int i);
        logic [63:0] ones;
        ones = {64{1'b1}};
        case (i)
            // empty message at reset seed hashes to zero
            0:  return mk_row(ones, 4'd0, 1'b1, 1'b1, 32'd0, 1'b1, 64'd0);
            // beats outside a message are dropped
            1:  return mk_row(64'h0123_4567_89ab_cdef, 4'd8, 1'b0, 1'b1, 32'd5, 1'b0, '0);
            2:  return mk_row(64'd0, 4'd8, 1'b0, 1'b0, 32'd0, 1'b0, '0);
            3:  return mk_row(64'd0, 4'd8, 1'b1, 1'b0, 32'hffff_ffff, 1'b0, '0);
            4:  return mk_row(ones, 4'd8, 1'b0, 1'b0, 32'd0, 1'b0, '0);
            // short word mid message, top byte must be masked
            5:  return mk_row(ones, 4'd7, 1'b0, 1'b0, 32'd0, 1'b0, '0);
            // byte counts above eight act as a full word
            6:  return mk_row(64'h0123_4567_89ab_cdef, 4'd15, 1'b0, 1'b0, 32'd0, 1'b0, '0);
            7:  return mk_row(64'h8000_0000_0000_0001, 4'd9, 1'b0, 1'b0, 32'd0, 1'b0, '0);
            8:  return mk_row(ones, 4'd0, 1'b0, 1'b1, 32'd7, 1'b0, '0);
            9:  return mk_row(ones, 4'd1, 1'b1, 1'b1, 32'd1, 1'b0, '0);
            10: return mk_row(64'hfedc_ba98_7654_3210, 4'd8, 1'b1, 1'b0, 32'd16, 1'b0, '0);
            // restart while a message is open
            11: return mk_row(64'h5555_5555_5555_5555, 4'd4, 1'b1, 1'b0, 32'd4, 1'b0, '0);
            12: return mk_row(64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, '0);
            13: return mk_row(ones, 4'd2, 1'b1, 1'b1, 32'd2, 1'b0, '0);
            14: return mk_row(ones, 4'd3, 1'b1, 1'b1, 32'd3, 1'b0, '0);
            15: return mk_row(ones, 4'd5, 1'b1, 1'b1, 32'd5, 1'b0, '0);
            16: return mk_row(ones, 4'd6, 1'b1, 1'b1, 32'd6, 1'b0, '0);
            17: return mk_row(ones, 4'd7, 1'b1, 1'b1, 32'd7, 1'b0, '0);
            18: return mk_row(ones, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, '0);
            // declared length disagrees with bytes sent
            19: return mk_row(ones, 4'd8, 1'b1, 1'b0, 32'd0, 1'b0, '0);
            20: return mk_row(64'd0, 4'd12, 1'b0, 1'b0, 32'd0, 1'b0, '0);
            default: return mk_row(ones, 4'd3, 1'b0, 1'b1, 32'd0, 1'b0, '0);
        endcase
    endfunction

    task automatic send_random_msg(input int max_words, inout int sent);
        beat_row_t b;
        bit        counted;
        int        nwords;
        int        tail;
        int        nbeats;
        if ($urandom_range(99) < 80)
        begin
            nwords = ($urandom_range(15) == 0 && max_words > 1) ? $urandom_range(20)
                                                                 : $urandom_range(max_words);
            tail   = $urandom_range(7);
            nbeats = nwords + ((tail != 0) ? 1 : 0);
            if (nbeats == 0)
                nbeats = 1;
            for (int i = 0; i < nbeats; i++)
            begin
                b.word       = {$urandom, $urandom};
                b.nbytes     = (i < nwords) ? 4'd8 : 4'(tail);
                b.first      = (i == 0);
                b.last       = (i == nbeats - 1);
                b.length     = ($urandom_range(99) < 85) ? 32'(nwords * 8 + tail) : $urandom;
                b.typed      = 1'b0;
                b.typed_hash = '0;
                send_beat(b, counted);
                if (counted)
                    sent++;
            end
        end
        else
        begin
            b.word       = {$urandom, $urandom};
            b.nbytes     = 4'($urandom_range(15));
            b.first      = 1'($urandom_range(1));
            b.last       = 1'($urandom_range(1));
            b.length     = $urandom;
            b.typed      = 1'b0;
            b.typed_hash = '0;
            send_beat(b, counted);
            if (counted)
                sent++;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        cfg_valid <= 1'b1;
        seed_in   <= s;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        seed_reg = s;
    endtask

    task automatic run_phase(input logic [31:0] s, input int sidle, input int rstall,
                             input int items, input int max_words, input bit hold);
        int sent;
        sent = 0;
        settle();
        write_seed(s);
        send_idle = sidle;
        recv_stall <= rstall;
        if (hold)
        begin
            hold_start <= 1'b1;
            @(posedge clk);
            hold_start <= 1'b0;
        end
        while (sent < items)
            send_random_msg(max_words, sent);
    endtask

    initial
    begin
        bit counted;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(directed_row(i), counted);

        run_phase(32'hffff_ffff, 0, 0, 320, 4, 1'b0);
        run_phase($urandom, 68, 0, 320, 4, 1'b0);
        run_phase(32'h0000_0000, 0, 68, 320, 4, 1'b0);
        run_phase(32'h8000_0001, 9, 9, 320, 4, 1'b0);
        // long receiver hold-off with short messages to back the block up
        run_phase($urandom, 0, 0, 300, 1, 1'b1);

        settle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
